[rtl/mbe_pkg.sv]
// shared types, constants and the arcsine table for the metaball texel unit
// no dependencies; every other file in rtl imports this package
package mbe_pkg;

   // sizes
   localparam int MAX_BALLS  = 8;
   localparam int TABLE_HALF = 256;      // power of two
   localparam int TH_LOG     = $clog2(TABLE_HALF);
   localparam int BALL_W     = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1;
   localparam int ACT_W      = $clog2(MAX_BALLS + 1);
   localparam int J_W        = TH_LOG + 2;   // table index 0 .. 2*TABLE_HALF
   localparam int K_W        = TH_LOG + 1;   // table entry 0 .. TABLE_HALF
   localparam int DIV_W      = 64;
   localparam int R2_W       = 51;

   // input op codes
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_VERTEX = 1'b1;

   // register indexes
   localparam logic [1:0] CSR_BALL_COUNT = 2'd0;
   localparam logic [1:0] CSR_ENV_MODE   = 2'd1;
   localparam logic [1:0] CSR_TEX_SCALE  = 2'd2;
   localparam logic [1:0] CSR_CHARGE     = 2'd3;

   localparam logic MODE_ASIN = 1'b0;

   typedef enum logic [4:0] {
      ST_IDLE, ST_READ, ST_DIFF, ST_SQ, ST_CHK, ST_RSQRT, ST_RWAIT,
      ST_DIV_U, ST_WAIT_U, ST_DIV_T, ST_WAIT_T, ST_MAG, ST_SHIFT, ST_N2,
      ST_NSQRT, ST_NWAIT, ST_DIV_N, ST_WAIT_N, ST_IDX, ST_TEX, ST_OUT
   } ctrl_state_type;

   typedef enum logic {SQ_SEL_R2, SQ_SEL_N2} sqrt_sel_type;
   typedef enum logic [1:0] {DIV_SEL_U, DIV_SEL_T, DIV_SEL_N} div_sel_type;

   typedef struct packed {
      logic              load_in;
      logic              clr_acc;
      logic              mem_we;
      logic              mem_rd;
      logic              diff_en;
      logic              sq_en;
      logic              sqrt_start;
      sqrt_sel_type      sqrt_sel;
      logic              r_en;
      logic              nrm_en;
      logic              div_start;
      div_sel_type       div_sel;
      logic              u_en;
      logic              acc_en;
      logic              mag_en;
      logic              shift_en;
      logic              n2_en;
      logic              nn_en;
      logic              idx_en;
      logic              tex_en;
      logic              out_load;
      logic [1:0]        comp;
      logic [BALL_W-1:0] ball;
   } cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] active;
      logic             r2_zero;
      logic             mx_hi;
      logic             mx_lo;
      logic             degen;
      logic             sqrt_done;
      logic             div_done;
      logic             out_free;
   } status_type;

   // arcsine table, worked out at elaboration
   typedef logic [15:0] asin_rom_type [0:TABLE_HALF];

   localparam int CORDIC_STEPS = 20;
   localparam int CORDIC_ANGLE [0:CORDIC_STEPS-1] = '{
      262144, 154753, 81767, 41506, 20834, 10427, 5215, 2608, 1304, 652,
      326, 163, 81, 41, 20, 10, 5, 3, 1, 1
   };

   function automatic longint unsigned isqrt_c(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      longint unsigned x;
      x = v;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint shr_zero(longint v, int s);
      if (v < 0) return -((-v) >>> s);
      return v >>> s;
   endfunction

   function automatic logic [15:0] rom_entry(int k);
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      if (k == 0) return 16'd0;
      x = longint'(isqrt_c(64'(TABLE_HALF * TABLE_HALF - k * k) << 36));
      y = longint'(k) <<< 18;
      z = 0;
      for (int s = 0; s < CORDIC_STEPS; s++) begin
         dx = shr_zero(y, s);
         dy = shr_zero(x, s);
         if (y > 0) begin
            x = x + dx;
            y = y - dy;
            z = z + CORDIC_ANGLE[s];
         end else begin
            x = x - dx;
            y = y + dy;
            z = z - CORDIC_ANGLE[s];
         end
      end
      if (z < 0) z = 0;
      if (z > 524288) z = 524288;
      return 16'((z + 8) >>> 4);
   endfunction

   function automatic asin_rom_type build_asin_rom();
      asin_rom_type rom;
      for (int k = 0; k <= TABLE_HALF; k++) rom[k] = rom_entry(k);
      return rom;
   endfunction

   localparam asin_rom_type ASIN_ROM = build_asin_rom();

endpackage

[rtl/mbe_isqrt.sv]
// iterative integer square root, two radicand bits per cycle
// depends on mbe_pkg
module mbe_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] rad,
   output logic        done,
   output logic [31:0] root
);
   import mbe_pkg::*;

   logic [63:0] rad_ff, rad_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [35:0] rem_sh;
   logic [35:0] trial;

   // one digit step
   always_comb begin
      rem_sh  = {rem_ff, rad_ff[63:62]};
      trial   = {2'b00, root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = rad;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[61:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = 34'(rem_sh - trial);
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = rem_sh[33:0];
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

[rtl/mbe_div.sv]
// restoring divider, one quotient bit per cycle
// depends on mbe_pkg
module mbe_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [mbe_pkg::DIV_W-1:0] num,
   input  logic [mbe_pkg::DIV_W-1:0] den,
   output logic                     done,
   output logic [mbe_pkg::DIV_W-1:0] quo
);
   import mbe_pkg::*;

   localparam int CNT_W = $clog2(DIV_W);

   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [DIV_W:0]   rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   shifted;

   // shift one numerator bit in, try the subtract
   always_comb begin
      shifted = {rem_ff[DIV_W-1:0], quo_ff[DIV_W-1]};
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = num;
         den_in  = den;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = shifted - {1'b0, den_ff};
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

[rtl/mbe_dp.sv]
// datapath: registers, centre store, field sum, normalize, texel lookup
// depends on mbe_pkg, mbe_isqrt, mbe_div
module mbe_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  mbe_pkg::cmd_type     cmd,
   output mbe_pkg::status_type  sts,
   input  logic [2:0]           req_ball_index,
   input  logic signed [23:0]   req_pos_x,
   input  logic signed [23:0]   req_pos_y,
   input  logic signed [23:0]   req_pos_z,
   input  logic                 csr_valid,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [15:0]          rsp_tex_u,
   output logic [15:0]          rsp_tex_v,
   output logic                 rsp_degenerate
);
   import mbe_pkg::*;

   // config registers
   logic [3:0]         ball_count_ff;
   logic               env_mode_ff;
   logic [15:0]        tex_scale_ff;
   logic signed [15:0] charge_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ball_count_ff <= 4'd3;
         env_mode_ff   <= 1'b0;
         tex_scale_ff  <= 16'd4096;
         charge_ff     <= 16'sd896;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BALL_COUNT: ball_count_ff <= csr_data[3:0];
            CSR_ENV_MODE:   env_mode_ff   <= csr_data[0];
            CSR_TEX_SCALE:  tex_scale_ff  <= csr_data;
            CSR_CHARGE:     charge_ff     <= $signed(csr_data);
            default:        ;
         endcase
      end
   end

   // centre store with valid bits, registered read
   logic [71:0]          mem [MAX_BALLS];
   logic [MAX_BALLS-1:0] mem_valid_ff;
   logic [71:0]          rd_ff;
   logic                 rd_valid_ff;
   logic                 wr_ok;

   assign wr_ok = int'(req_ball_index) < MAX_BALLS;

   always_ff @(posedge clock) begin
      if (cmd.mem_we && wr_ok) begin
         mem[BALL_W'(req_ball_index)] <= {req_pos_z, req_pos_y, req_pos_x};
      end
      if (cmd.mem_rd) begin
         rd_ff       <= mem[cmd.ball];
         rd_valid_ff <= mem_valid_ff[cmd.ball];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_valid_ff <= '0;
      end else if (cmd.mem_we && wr_ok) begin
         mem_valid_ff[BALL_W'(req_ball_index)] <= 1'b1;
      end
   end

   // active ball count, saturated
   assign sts.active = (int'(ball_count_ff) > MAX_BALLS) ? ACT_W'(MAX_BALLS)
                                                         : ACT_W'(ball_count_ff);

   // vertex and difference registers
   logic signed [23:0] vert_ff [3];
   logic signed [24:0] d_ff [3];
   logic [24:0]        dabs [3];
   logic [23:0]        cen [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         cen[c]  = rd_valid_ff ? rd_ff[c*24 +: 24] : 24'd0;
         dabs[c] = d_ff[c][24] ? 25'(-d_ff[c]) : 25'(d_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         vert_ff[0] <= req_pos_x;
         vert_ff[1] <= req_pos_y;
         vert_ff[2] <= req_pos_z;
      end
      if (cmd.diff_en) begin
         for (int c = 0; c < 3; c++) begin
            d_ff[c] <= {vert_ff[c][23], vert_ff[c]} - $signed({cen[c][23], cen[c]});
         end
      end
   end

   // shared squaring multiplier
   logic [63:0] mag_ff [3];
   logic [31:0] mul_a;
   logic [63:0] mul_p;

   assign mul_a = cmd.sq_en ? 32'(dabs[cmd.comp]) : mag_ff[cmd.comp][31:0];
   assign mul_p = 64'(mul_a) * 64'(mul_a);

   // iterative units
   logic [R2_W-1:0]  r2_ff;
   logic [31:0]      r_ff;
   logic [31:0]      nrm_ff;
   logic [63:0]      n2_ff;
   logic [30:0]      u_ff;
   logic [63:0]      sqrt_rad;
   logic [31:0]      sqrt_root;
   logic [DIV_W-1:0] div_num;
   logic [DIV_W-1:0] div_den;
   logic [DIV_W-1:0] div_quo;

   assign sqrt_rad = (cmd.sqrt_sel == SQ_SEL_R2) ? 64'(r2_ff) : n2_ff;

   always_comb begin
      case (cmd.div_sel)
         DIV_SEL_U: begin
            div_num = DIV_W'({dabs[cmd.comp], 30'd0});
            div_den = DIV_W'(r_ff);
         end
         DIV_SEL_T: begin
            div_num = DIV_W'({u_ff, 26'd0});
            div_den = DIV_W'(r2_ff);
         end
         default: begin
            div_num = DIV_W'({mag_ff[cmd.comp][29:0], 15'd0});
            div_den = DIV_W'(nrm_ff);
         end
      endcase
   end

   mbe_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.sqrt_start),
      .rad   (sqrt_rad),
      .done  (sts.sqrt_done),
      .root  (sqrt_root)
   );

   mbe_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (sts.div_done),
      .quo   (div_quo)
   );

   // field sum and normalization
   logic signed [63:0] sum_ff [3];
   logic [63:0]        mag_in [3];
   logic [63:0]        mx_ff;
   logic [63:0]        mx_in;
   logic               degen_ff;
   logic signed [63:0] term;
   logic signed [16:0] nn_ff [2];
   logic [16:0]        nv;
   logic               nneg;

   assign term = $signed(div_quo);
   assign nv   = div_quo[16:0];
   assign nneg = sum_ff[cmd.comp][63] ^ charge_ff[15];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         mag_in[c] = sum_ff[c][63] ? 64'(-sum_ff[c]) : 64'(sum_ff[c]);
      end
      mx_in = mag_in[0];
      if (mag_in[1] > mx_in) mx_in = mag_in[1];
      if (mag_in[2] > mx_in) mx_in = mag_in[2];
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_acc) begin
         for (int c = 0; c < 3; c++) sum_ff[c] <= '0;
         nn_ff[0] <= '0;
         nn_ff[1] <= '0;
      end
      if (cmd.diff_en) r2_ff <= '0;
      if (cmd.sq_en) r2_ff <= r2_ff + R2_W'(mul_p);
      if (cmd.r_en) r_ff <= sqrt_root;
      if (cmd.nrm_en) nrm_ff <= sqrt_root;
      if (cmd.u_en) u_ff <= div_quo[30:0];
      if (cmd.acc_en) begin
         sum_ff[cmd.comp] <= d_ff[cmd.comp][24] ? sum_ff[cmd.comp] - term
                                                : sum_ff[cmd.comp] + term;
      end
      if (cmd.mag_en) begin
         for (int c = 0; c < 3; c++) mag_ff[c] <= mag_in[c];
         mx_ff    <= mx_in;
         degen_ff <= (mx_in == 64'd0) || (charge_ff == 16'sd0);
         n2_ff    <= '0;
      end
      // common shift toward [2^29, 2^30)
      if (cmd.shift_en) begin
         if (mx_ff[63:30] != '0) begin
            mx_ff <= mx_ff >> 1;
            for (int c = 0; c < 3; c++) mag_ff[c] <= mag_ff[c] >> 1;
         end else begin
            mx_ff <= mx_ff << 1;
            for (int c = 0; c < 3; c++) mag_ff[c] <= mag_ff[c] << 1;
         end
      end
      if (cmd.n2_en) n2_ff <= n2_ff + mul_p;
      if (cmd.nn_en) begin
         nn_ff[cmd.comp[0]] <= nneg ? -$signed(nv) : $signed(nv);
      end
   end

   assign sts.r2_zero = (r2_ff == '0);
   assign sts.mx_hi   = (mx_ff[63:30] != '0);
   assign sts.mx_lo   = (mx_ff[63:29] == '0);
   assign sts.degen   = degen_ff;

   // table index and texel
   logic [J_W-1:0]      j_ff [2];
   logic [15:0]         tex_ff [2];
   logic [17:0]         biased [2];
   logic signed [J_W:0] ti [2];
   logic [K_W-1:0]      tk [2];
   logic [15:0]         ta [2];
   logic [16:0]         tval [2];
   logic [32:0]         prod0 [2];
   logic [16+J_W-1:0]   prod1 [2];

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         biased[c] = {nn_ff[c][16], nn_ff[c]} + 18'd32768;
         ti[c]     = $signed({1'b0, j_ff[c]}) - $signed((J_W+1)'(TABLE_HALF));
         tk[c]     = ti[c][J_W] ? K_W'(-ti[c]) : K_W'(ti[c]);
         ta[c]     = ASIN_ROM[tk[c]];
         tval[c]   = ti[c][J_W] ? 17'd32768 - 17'(ta[c]) : 17'd32768 + 17'(ta[c]);
         prod0[c]  = 33'(tex_scale_ff) * 33'(tval[c]);
         prod1[c]  = (16+J_W)'(tex_scale_ff) * (16+J_W)'(j_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 2; c++) begin
         if (cmd.idx_en) j_ff[c] <= J_W'(biased[c][16:0] >> (15 - TH_LOG));
         if (cmd.tex_en) begin
            tex_ff[c] <= (env_mode_ff == MODE_ASIN) ? prod0[c][31:16]
                                                    : prod1[c][TH_LOG+1 +: 16];
         end
      end
   end

   // result register
   logic        rsp_valid_ff;
   logic [15:0] rsp_u_ff;
   logic [15:0] rsp_v_ff;
   logic        rsp_degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_u_ff     <= tex_ff[0];
         rsp_v_ff     <= tex_ff[1];
         rsp_degen_ff <= degen_ff;
      end
   end

   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tex_u      = rsp_u_ff;
   assign rsp_tex_v      = rsp_v_ff;
   assign rsp_degenerate = rsp_degen_ff;
endmodule

[rtl/mbe_ctrl.sv]
// sequencer: steps balls and components, drives datapath commands
// depends on mbe_pkg
module mbe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_op,
   output logic                 req_stall,
   input  mbe_pkg::status_type  sts,
   output mbe_pkg::cmd_type     cmd
);
   import mbe_pkg::*;

   ctrl_state_type    state_ff, state_in;
   logic [BALL_W-1:0] ball_ff;
   logic [1:0]        comp_ff;
   logic              last_ball;
   logic              take_vertex;

   assign last_ball   = (ACT_W'(ball_ff) + ACT_W'(1)) == sts.active;
   assign take_vertex = (state_ff == ST_IDLE) && req_valid && (req_op == OP_VERTEX);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (take_vertex) state_in = (sts.active == '0) ? ST_MAG : ST_READ;
         ST_READ:   state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_SQ;
         ST_SQ:     if (comp_ff == 2'd2) state_in = ST_CHK;
         ST_CHK: begin
            if (!sts.r2_zero) state_in = ST_RSQRT;
            else state_in = last_ball ? ST_MAG : ST_READ;
         end
         ST_RSQRT:  state_in = ST_RWAIT;
         ST_RWAIT:  if (sts.sqrt_done) state_in = ST_DIV_U;
         ST_DIV_U:  state_in = ST_WAIT_U;
         ST_WAIT_U: if (sts.div_done) state_in = ST_DIV_T;
         ST_DIV_T:  state_in = ST_WAIT_T;
         ST_WAIT_T: begin
            if (sts.div_done) begin
               if (comp_ff != 2'd2) state_in = ST_DIV_U;
               else state_in = last_ball ? ST_MAG : ST_READ;
            end
         end
         ST_MAG:    state_in = ST_SHIFT;
         ST_SHIFT: begin
            if (sts.degen) state_in = ST_IDX;
            else if (!sts.mx_hi && !sts.mx_lo) state_in = ST_N2;
         end
         ST_N2:     if (comp_ff == 2'd2) state_in = ST_NSQRT;
         ST_NSQRT:  state_in = ST_NWAIT;
         ST_NWAIT:  if (sts.sqrt_done) state_in = ST_DIV_N;
         ST_DIV_N:  state_in = ST_WAIT_N;
         ST_WAIT_N: if (sts.div_done) state_in = (comp_ff == 2'd1) ? ST_IDX : ST_DIV_N;
         ST_IDX:    state_in = ST_TEX;
         ST_TEX:    state_in = ST_OUT;
         ST_OUT:    if (sts.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd          = '0;
      cmd.comp     = comp_ff;
      cmd.ball     = ball_ff;
      cmd.sqrt_sel = SQ_SEL_R2;
      cmd.div_sel  = DIV_SEL_U;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load_in = take_vertex;
            cmd.clr_acc = take_vertex;
            cmd.mem_we  = req_valid && (req_op == OP_LOAD);
         end
         ST_READ:   cmd.mem_rd = 1'b1;
         ST_DIFF:   cmd.diff_en = 1'b1;
         ST_SQ:     cmd.sq_en = 1'b1;
         ST_CHK:    ;
         ST_RSQRT:  cmd.sqrt_start = 1'b1;
         ST_RWAIT:  cmd.r_en = sts.sqrt_done;
         ST_DIV_U:  cmd.div_start = 1'b1;
         ST_WAIT_U: cmd.u_en = sts.div_done;
         ST_DIV_T: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_T;
         end
         ST_WAIT_T: begin
            cmd.div_sel = DIV_SEL_T;
            cmd.acc_en  = sts.div_done;
         end
         ST_MAG:    cmd.mag_en = 1'b1;
         ST_SHIFT:  cmd.shift_en = !sts.degen && (sts.mx_hi || sts.mx_lo);
         ST_N2:     cmd.n2_en = 1'b1;
         ST_NSQRT: begin
            cmd.sqrt_start = 1'b1;
            cmd.sqrt_sel   = SQ_SEL_N2;
         end
         ST_NWAIT: begin
            cmd.sqrt_sel = SQ_SEL_N2;
            cmd.nrm_en   = sts.sqrt_done;
         end
         ST_DIV_N: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_N;
         end
         ST_WAIT_N: begin
            cmd.div_sel = DIV_SEL_N;
            cmd.nn_en   = sts.div_done;
         end
         ST_IDX:    cmd.idx_en = 1'b1;
         ST_TEX:    cmd.tex_en = 1'b1;
         ST_OUT:    cmd.out_load = sts.out_free;
         default:   ;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   // state, ball and component counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ball_ff  <= '0;
         comp_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (take_vertex) ball_ff <= '0;
         if ((state_ff == ST_CHK && sts.r2_zero && !last_ball) ||
             (state_ff == ST_WAIT_T && sts.div_done && comp_ff == 2'd2 && !last_ball)) begin
            ball_ff <= ball_ff + BALL_W'(1);
         end
         if (state_ff == ST_SQ || state_ff == ST_N2 ||
             (state_ff == ST_WAIT_T && sts.div_done)) begin
            comp_ff <= (comp_ff == 2'd2) ? 2'd0 : comp_ff + 2'd1;
         end
         if (state_ff == ST_WAIT_N && sts.div_done) begin
            comp_ff <= (comp_ff == 2'd1) ? 2'd0 : comp_ff + 2'd1;
         end
      end
   end
endmodule

[rtl/metaball_normal_envmap_texel.sv]
// top level of the metaball normal to environment texel unit
// depends on mbe_pkg, mbe_ctrl, mbe_dp
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  op, ball_index, pos_x, pos_y, pos_z
//   rsp      out        rsp_valid / rsp_stall  tex_u, tex_v, degenerate
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// a load beat goes straight into the centre store; a vertex beat takes longer
// with each normalizing shift (none when degenerate) and with each active
// ball, the more at nonzero distance, where it needs six divides on the
// 64-step divider and one 32-step root; the normal needs two more divides and a root.
// reset is synchronous and restores the register defaults and empty centres.
// req_stall is high while a vertex is in work; a waiting result does not
// block the next beat until that vertex is ready to be written out.
module metaball_normal_envmap_texel (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [2:0]         req_ball_index,
   input  logic signed [23:0] req_pos_x,
   input  logic signed [23:0] req_pos_y,
   input  logic signed [23:0] req_pos_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_tex_u,
   output logic [15:0]        rsp_tex_v,
   output logic               rsp_degenerate,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import mbe_pkg::*;

   cmd_type    cmd;
   status_type sts;

   assign csr_ready = 1'b1;

   mbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mbe_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_ball_index (req_ball_index),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tex_u      (rsp_tex_u),
      .rsp_tex_v      (rsp_tex_v),
      .rsp_degenerate (rsp_degenerate)
   );
endmodule

[tb/metaball_normal_envmap_texel_tb.sv]
// self-checking bench for metaball_normal_envmap_texel: random and directed load and vertex beats
// depends on mbe_pkg and the rtl top level; the texel predictor lives in the scoreboard class below
module metaball_normal_envmap_texel_tb;
   import mbe_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_op;
   logic [2:0]         req_ball_index;
   logic signed [23:0] req_pos_x;
   logic signed [23:0] req_pos_y;
   logic signed [23:0] req_pos_z;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [15:0]        rsp_tex_u;
   logic [15:0]        rsp_tex_v;
   logic               rsp_degenerate;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [15:0]        csr_data;

   metaball_normal_envmap_texel i_dut (.*);

   typedef struct {
      logic [15:0] tex_u;
      logic [15:0] tex_v;
      logic        degen;
   } texel_beat_type;

   // texel predictor and queue of pending texels
   class texel_scoreboard;
      texel_beat_type pending_texels[$];
      int unsigned errors;
      int unsigned vertices;
      int unsigned loads;
      int unsigned texels_seen;
      int unsigned degen_seen;
      int          centre[MAX_BALLS][3];
      logic [3:0]  ball_count;
      logic        env_mode;
      logic [15:0] tex_scale;
      int          charge;
      int          asin_tab[TABLE_HALF+1];

      function new();
         for (int k = 0; k <= TABLE_HALF; k++) asin_tab[k] = cordic_asin(k);
         foreach (centre[b, c]) centre[b][c] = 0;
         ball_count = 3;
         env_mode   = MODE_ASIN;
         tex_scale  = 16'd4096;
         charge     = 896;
      endfunction

      static function longint unsigned int_root(longint unsigned v);
         longint unsigned r;
         longint unsigned b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      static function longint trunc_shift(longint v, int s);
         longint unsigned m;
         if (v < 0) begin
            m = longint'(-v);
            return -longint'(m >> s);
         end
         m = v;
         return longint'(m >> s);
      endfunction

      // vectoring rotation, angle in units of pi/2^20
      static function int cordic_asin(int k);
         longint x;
         longint y;
         longint z;
         longint dx;
         longint dy;
         longint unsigned h2;
         int steps[20] = '{262144, 154753, 81767, 41506, 20834, 10427, 5215, 2608,
                           1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
         if (k == 0) return 0;
         h2 = longint'(TABLE_HALF * TABLE_HALF - k * k);
         x = longint'(int_root(h2 << 36));
         y = longint'(k) << 18;
         z = 0;
         for (int s = 0; s < 20; s++) begin
            dx = trunc_shift(y, s);
            dy = trunc_shift(x, s);
            if (y > 0) begin
               x = x + dx;
               y = y - dy;
               z = z + steps[s];
            end else begin
               x = x - dx;
               y = y + dy;
               z = z - steps[s];
            end
         end
         if (z < 0) z = 0;
         if (z > 524288) z = 524288;
         return int'((z + 8) >> 4);
      endfunction

      function void set_reg(logic [1:0] idx, logic [15:0] val);
         case (idx)
            CSR_BALL_COUNT: ball_count = val[3:0];
            CSR_ENV_MODE:   env_mode   = val[0];
            CSR_TEX_SCALE:  tex_scale  = val;
            CSR_CHARGE:     charge     = int'($signed(val));
         endcase
      endfunction

      function logic [15:0] texel_of(int n);
         longint unsigned j;
         longint unsigned p;
         int              a;
         int              i;
         j = longint'(((n + 32768) * TABLE_HALF) >> 15);
         if (env_mode != MODE_ASIN) return 16'((tex_scale * j) / (2 * TABLE_HALF));
         i = int'(j) - TABLE_HALF;
         a = (i < 0) ? -asin_tab[-i] : asin_tab[i];
         p = longint'(tex_scale) * longint'(32768 + a);
         return 16'(p >> 16);
      endfunction

      function texel_beat_type predict(int px, int py, int pz);
         texel_beat_type  res;
         longint          acc[3];
         longint          d[3];
         longint unsigned mag[3];
         longint unsigned r2, r, m, u, t, mx, nrm;
         int              pos[3];
         int              nv[2];
         int              active;
         pos = '{px, py, pz};
         acc = '{0, 0, 0};
         nv  = '{0, 0};
         active = (ball_count > MAX_BALLS) ? MAX_BALLS : ball_count;
         // per-ball field gradient
         for (int b = 0; b < active; b++) begin
            r2 = 0;
            for (int c = 0; c < 3; c++) begin
               d[c] = longint'(pos[c]) - longint'(centre[b][c]);
               r2 += longint'(d[c] * d[c]);
            end
            if (r2 == 0) continue;
            r = int_root(r2);
            for (int c = 0; c < 3; c++) begin
               m = (d[c] < 0) ? -d[c] : d[c];
               u = (m << 30) / r;
               t = (u << 26) / r2;
               acc[c] += (d[c] < 0) ? -longint'(t) : longint'(t);
            end
         end
         mx = 0;
         for (int c = 0; c < 3; c++) begin
            mag[c] = (acc[c] < 0) ? -acc[c] : acc[c];
            if (mag[c] > mx) mx = mag[c];
         end
         res.degen = (mx == 0) || (charge == 0);
         // normalize into [2^29, 2^30) then divide by the norm
         if (!res.degen) begin
            while (mx >= (64'd1 << 30)) begin
               mx = mx >> 1;
               for (int c = 0; c < 3; c++) mag[c] = mag[c] >> 1;
            end
            while (mx < (64'd1 << 29)) begin
               mx = mx << 1;
               for (int c = 0; c < 3; c++) mag[c] = mag[c] << 1;
            end
            nrm = int_root(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
            for (int c = 0; c < 2; c++) begin
               nv[c] = int'((mag[c] << 15) / nrm);
               if ((acc[c] < 0) != (charge < 0)) nv[c] = -nv[c];
            end
         end
         res.tex_u = texel_of(nv[0]);
         res.tex_v = texel_of(nv[1]);
         return res;
      endfunction

      function void note_beat(logic op, logic [2:0] idx, int px, int py, int pz);
         if (op == OP_LOAD) begin
            loads++;
            if (idx < MAX_BALLS) centre[idx] = '{px, py, pz};
         end else begin
            vertices++;
            pending_texels.push_back(predict(px, py, pz));
         end
      endfunction

      function void check_beat(logic [15:0] u, logic [15:0] v, logic dg);
         texel_beat_type exp_t;
         if (pending_texels.size() == 0) begin
            $error("texel beat with nothing pending: u=%0h v=%0h degenerate=%0b", u, v, dg);
            errors++;
            return;
         end
         exp_t = pending_texels.pop_front();
         texels_seen++;
         if (dg) degen_seen++;
         if (u !== exp_t.tex_u) begin
            $error("tex_u expected %0h actual %0h", exp_t.tex_u, u);
            errors++;
         end
         if (v !== exp_t.tex_v) begin
            $error("tex_v expected %0h actual %0h", exp_t.tex_v, v);
            errors++;
         end
         if (dg !== exp_t.degen) begin
            $error("degenerate expected %0b actual %0b", exp_t.degen, dg);
            errors++;
         end
      endfunction
   endclass

   texel_scoreboard sb = new();
   bit              req_idle_on = 1;
   bit              rsp_idle_on = 1;
   int              hold_left = 0;
   int              rsp_burst = 0;
   int              csr_writes = 0;

   // clock
   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #500_000_000;
      $display("metaball_normal_envmap_texel test failed");
      $finish;
   end

   // result side: long holds, random stall bursts
   initial begin
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1;
            hold_left--;
         end else if (rsp_burst > 0) begin
            rsp_stall <= 1;
            rsp_burst--;
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1;
            rsp_burst = $urandom_range(0, 2);
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   // check each texel beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_beat(rsp_tex_u, rsp_tex_v, rsp_degenerate);
   end

   task automatic send_beat(logic op, logic [2:0] idx, int px, int py, int pz);
      int gap;
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 3);
         @(negedge clock);
         req_valid <= 0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1;
      req_op         <= op;
      req_ball_index <= idx;
      req_pos_x      <= 24'(px);
      req_pos_y      <= 24'(py);
      req_pos_z      <= 24'(pz);
      do @(posedge clock); while (req_stall);
      sb.note_beat(op, idx, px, py, pz);
   endtask

   // stop offering and wait until every texel is back and the unit has gone quiet
   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (sb.pending_texels.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, val);
      csr_writes++;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic int rand_pos();
      case ($urandom_range(0, 9))
         0:       return -8388608;
         1:       return 8388607;
         2:       return 0;
         3, 4, 5: return int'($signed(24'($urandom)));
         default: return $urandom_range(0, 1 << 19) - (1 << 18);
      endcase
   endfunction

   task automatic rand_vertex();
      int b;
      int sc;
      int p[3];
      b = $urandom_range(0, MAX_BALLS - 1);
      sc = $urandom_range(2, 20);
      for (int c = 0; c < 3; c++) begin
         if ($urandom_range(0, 2) != 0)
            p[c] = sb.centre[b][c] + ($urandom_range(0, 1 << sc) - (1 << (sc - 1)));
         else
            p[c] = rand_pos();
         if (p[c] > 8388607) p[c] = 8388607;
         if (p[c] < -8388608) p[c] = -8388608;
      end
      send_beat(OP_VERTEX, 3'($urandom), p[0], p[1], p[2]);
   endtask

   task automatic rand_settings();
      int pick;
      pick = $urandom_range(0, 19);
      write_reg(CSR_BALL_COUNT, 16'((pick < 12) ? $urandom_range(1, 2) :
                                    (pick < 17) ? $urandom_range(3, 4) :
                                    (pick < 18) ? 0 : $urandom_range(8, 15)));
      write_reg(CSR_ENV_MODE, 16'($urandom));
      pick = $urandom_range(0, 5);
      write_reg(CSR_TEX_SCALE, (pick == 0) ? 16'hffff : (pick == 1) ? 16'h0000 : 16'($urandom));
      pick = $urandom_range(0, 7);
      write_reg(CSR_CHARGE, (pick == 0) ? 16'h8000 : (pick == 1) ? 16'h7fff :
                            (pick == 2) ? 16'h0000 : 16'($urandom));
   endtask

   initial begin
      reset          = 1;
      req_valid      = 0;
      req_op         = OP_LOAD;
      req_ball_index = 0;
      req_pos_x      = 0;
      req_pos_y      = 0;
      req_pos_z      = 0;
      csr_valid      = 0;
      csr_index      = CSR_BALL_COUNT;
      csr_data       = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: reset settings, extremes, zero distance, degenerate cases
      send_beat(OP_VERTEX, 0, 65536, -65536, 0);
      send_beat(OP_LOAD, 0, 65536, 0, 0);
      send_beat(OP_LOAD, 1, -65536, 0, 0);
      send_beat(OP_LOAD, 2, 8388607, -8388608, 8388607);
      send_beat(OP_VERTEX, 7, 0, 0, 0);
      send_beat(OP_VERTEX, 0, 65536, 0, 0);
      send_beat(OP_VERTEX, 0, 8388607, 8388607, 8388607);
      send_beat(OP_VERTEX, 0, -8388608, -8388608, -8388608);
      send_beat(OP_LOAD, 7, -8388608, 8388607, -8388608);
      drain();
      write_reg(CSR_BALL_COUNT, 0);
      send_beat(OP_VERTEX, 0, 12345, -999, 77);
      drain();
      write_reg(CSR_BALL_COUNT, 15);
      write_reg(CSR_CHARGE, 16'h0000);
      send_beat(OP_VERTEX, 0, 300000, 20000, -5000);
      drain();
      write_reg(CSR_CHARGE, 16'h8000);
      write_reg(CSR_ENV_MODE, 1);
      write_reg(CSR_TEX_SCALE, 16'hffff);
      send_beat(OP_VERTEX, 0, 300000, 20000, -5000);
      send_beat(OP_VERTEX, 0, -8388608, 8388607, 0);
      drain();
      write_reg(CSR_CHARGE, 16'h7fff);
      write_reg(CSR_TEX_SCALE, 16'h0000);
      send_beat(OP_VERTEX, 0, 65536, 0, 0);
      drain();
      write_reg(CSR_ENV_MODE, 0);
      write_reg(CSR_TEX_SCALE, 16'hffff);
      write_reg(CSR_BALL_COUNT, 2);
      send_beat(OP_VERTEX, 0, 0, 65536, 0);
      send_beat(OP_VERTEX, 0, 0, -65536, 1);
      drain();

      // random phases of 100 beats, new settings between phases
      for (int ph = 0; ph < 16; ph++) begin
         rand_settings();
         if (ph >= 14) begin
            req_idle_on = 0;
            rsp_idle_on = 0;
         end
         if (ph == 3) begin
            write_reg(CSR_BALL_COUNT, 1);
            hold_left = 5000;
         end
         for (int n = 0; n < 100; n++) begin
            if ($urandom_range(0, 2) == 0)
               send_beat(OP_LOAD, 3'($urandom), rand_pos(), rand_pos(), rand_pos());
            else
               rand_vertex();
         end
         drain();
      end

      if (sb.pending_texels.size() != 0) begin
         $error("%0d texels never arrived", sb.pending_texels.size());
         sb.errors++;
      end
      $display("covered %0d vertex beats (%0d degenerate), %0d loads, %0d register writes",
               sb.vertices, sb.degen_seen, sb.loads, csr_writes);
      if (sb.errors == 0)
         $display("metaball_normal_envmap_texel test passed");
      else
         $display("metaball_normal_envmap_texel test failed");
      $finish;
   end

endmodule
